### src/rgbpal_pkg.sv
// ---------------------------------------------------------------------------
// rgbpal_pkg
// Shared types and constants of the RGBA to indexed palette builder.
// ---------------------------------------------------------------------------
package rgbpal_pkg;

  // field widths of the channels
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CFG_DIM_W  = 11;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned KEY_W      = 3 * CHAN_W;

  // reset values of the configuration registers
  localparam logic [CFG_DIM_W-1:0] RESET_DIM       = CFG_DIM_W'(32);
  localparam logic [CHAN_W-1:0]    RESET_THRESHOLD = CHAN_W'(127);

  // index given to an unknown color once the table is full
  localparam logic [INDEX_W-1:0] FULL_INDEX = INDEX_W'(1);
  // palette entry flag and the empty color
  localparam logic [COLOR_W-1:0] ENTRY_FLAG  = 16'h8000;
  localparam logic [COLOR_W-1:0] NO_COLOR    = 16'h0000;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH     = 3'd0,
    CFG_IMAGE_HEIGHT    = 3'd1,
    CFG_TEXTURE_WIDTH   = 3'd2,
    CFG_TEXTURE_HEIGHT  = 3'd3,
    CFG_ALPHA_THRESHOLD = 3'd4
  } cfg_reg_e;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] image_width;
    logic [CFG_DIM_W-1:0] image_height;
    logic [CFG_DIM_W-1:0] texture_width;
    logic [CFG_DIM_W-1:0] texture_height;
    logic [CHAN_W-1:0]    alpha_threshold;
  } cfg_t;

  // classified texel passed from front to back
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             visible;
    logic             first;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic               new_entry;
    logic [INDEX_W-1:0] entry_slot;
    logic [COLOR_W-1:0] entry_color;
    logic [COUNT_W-1:0] palette_count;
    logic               last_pixel;
  } result_t;

  // palette entry from a 24-bit key {r, g, b}: flag in bit 15, then 5-bit blue, green, red from high to low
  function automatic logic [COLOR_W-1:0] rgb555(input logic [KEY_W-1:0] key);
    return ENTRY_FLAG | {1'b0, key[7:3], key[15:11], key[23:19]};
  endfunction

endpackage

### src/rgbpal_intf.sv
// ---------------------------------------------------------------------------
// rgbpal interfaces
// Valid/ready channels for texels, results and configuration writes.
// ---------------------------------------------------------------------------
interface rgbpal_texel_if;
  logic                         valid;
  logic                         ready;
  logic [rgbpal_pkg::CHAN_W-1:0] red;
  logic [rgbpal_pkg::CHAN_W-1:0] green;
  logic [rgbpal_pkg::CHAN_W-1:0] blue;
  logic [rgbpal_pkg::CHAN_W-1:0] alpha;
  logic                         first_pixel;

  modport source (output valid, red, green, blue, alpha, first_pixel, input ready);
  modport sink   (input valid, red, green, blue, alpha, first_pixel, output ready);
endinterface

interface rgbpal_result_if;
  logic                          valid;
  logic                          ready;
  logic [rgbpal_pkg::INDEX_W-1:0] pixel_index;
  logic                          new_entry;
  logic [rgbpal_pkg::INDEX_W-1:0] entry_slot;
  logic [rgbpal_pkg::COLOR_W-1:0] entry_color;
  logic [rgbpal_pkg::COUNT_W-1:0] palette_count;
  logic                          last_pixel;

  modport source (output valid, pixel_index, new_entry, entry_slot, entry_color,
                  palette_count, last_pixel, input ready);
  modport sink   (input valid, pixel_index, new_entry, entry_slot, entry_color,
                  palette_count, last_pixel, output ready);
endinterface

interface rgbpal_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rgbpal_pkg::CFG_ADDR_W-1:0] addr;
  logic [rgbpal_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### src/rgba_to_indexed_palette_builder.sv
// ---------------------------------------------------------------------------
// rgba_to_indexed_palette_builder
// Builds an 8-bit indexed palette from a raster stream of RGBA texels.
// ---------------------------------------------------------------------------
// One texel word in gives one result word out. The front classifies each
// texel in the cycle it is taken and pushes it into a two-deep queue; the
// back processes one texel at a time. Padding and transparent texels go
// straight from the idle to the emit state; an opaque texel is looked up
// in the search state against the colors already in the table, which
// reads the color tag memory through its single read port, one entry a cycle,
// and stops early on a hit. The table holds up to PALETTE_SIZE-1 colors;
// slot 0 is transparency and, once the table is full, unknown colors map
// to index 1. A texel with first_pixel set clears the table and restarts
// the raster position. Configuration writes (index 0..4: image width,
// image height, texture width, texture height, alpha threshold) are always
// ready and must only be issued while no texel is in flight.
// ---------------------------------------------------------------------------
module rgba_to_indexed_palette_builder #(
  parameter int unsigned PALETTE_SIZE  = 256,
  parameter int unsigned MAX_DIMENSION = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rgbpal_cfg_if.sink     cfg_i,
  rgbpal_texel_if.sink   texel_i,
  rgbpal_result_if.source result_o
);

  rgbpal_pkg::cfg_t    cfg_q;
  rgbpal_pkg::item_t   push_item, pop_item;
  rgbpal_pkg::result_t res;
  logic                push_valid, push_ready, pop_valid, pop_ready;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width     <= rgbpal_pkg::RESET_DIM;
      cfg_q.image_height    <= rgbpal_pkg::RESET_DIM;
      cfg_q.texture_width   <= rgbpal_pkg::RESET_DIM;
      cfg_q.texture_height  <= rgbpal_pkg::RESET_DIM;
      cfg_q.alpha_threshold <= rgbpal_pkg::RESET_THRESHOLD;
    end else if (cfg_i.valid) begin
      case (rgbpal_pkg::cfg_reg_e'(cfg_i.addr))
        rgbpal_pkg::CFG_IMAGE_WIDTH:     cfg_q.image_width    <= cfg_i.data;
        rgbpal_pkg::CFG_IMAGE_HEIGHT:    cfg_q.image_height   <= cfg_i.data;
        rgbpal_pkg::CFG_TEXTURE_WIDTH:   cfg_q.texture_width  <= cfg_i.data;
        rgbpal_pkg::CFG_TEXTURE_HEIGHT:  cfg_q.texture_height <= cfg_i.data;
        rgbpal_pkg::CFG_ALPHA_THRESHOLD: begin
          cfg_q.alpha_threshold <= cfg_i.data[rgbpal_pkg::CHAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // front: coordinates and classification
  rgbpal_front #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .texel_i      (texel_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // queue between front and back
  rgbpal_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // back: table lookup and result register
  rgbpal_back #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_o       (res)
  );

  // result fields
  assign result_o.pixel_index   = res.pixel_index;
  assign result_o.new_entry     = res.new_entry;
  assign result_o.entry_slot    = res.entry_slot;
  assign result_o.entry_color   = res.entry_color;
  assign result_o.palette_count = res.palette_count;
  assign result_o.last_pixel    = res.last_pixel;

  // a new entry is the texel's own index and carries the entry flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.new_entry |->
      result_o.pixel_index == result_o.entry_slot && result_o.entry_color[15])
    else $error("new entry slot or color mismatch");

  // without a new entry, slot and color stay empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.new_entry |->
      result_o.entry_slot == '0 && result_o.entry_color == rgbpal_pkg::NO_COLOR)
    else $error("stray entry fields");

  // the palette always counts the reserved slot and never exceeds its size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.palette_count != '0 &&
      result_o.palette_count <= rgbpal_pkg::COUNT_W'(PALETTE_SIZE))
    else $error("palette count out of range");

  // a transparent texel never adds an entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.pixel_index == '0 |-> !result_o.new_entry)
    else $error("transparent texel added an entry");

endmodule

### src/rgbpal_front.sv
// ---------------------------------------------------------------------------
// rgbpal_front
// Tracks raster coordinates and classifies each texel as padding,
// transparent or opaque before it enters the queue.
// ---------------------------------------------------------------------------
module rgbpal_front #(
  parameter int unsigned MAX_DIMENSION = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rgbpal_pkg::cfg_t    cfg_i,
  rgbpal_texel_if.sink        texel_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output rgbpal_pkg::item_t   push_item_o
);

  localparam int unsigned CW    = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned XW    =
    ((DIM_W > rgbpal_pkg::CFG_DIM_W) ? DIM_W : rgbpal_pkg::CFG_DIM_W) + 1;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_DIMENSION);

  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [CW-1:0] col_cur, row_cur;
  logic [XW-1:0] tw_x, th_x, col_inc, row_inc;
  logic          end_col, end_row, accept;

  // clamp a texture dimension into 1..MAX_DIMENSION
  function automatic logic [XW-1:0] eff_dim(input logic [rgbpal_pkg::CFG_DIM_W-1:0] d);
    logic [XW-1:0] dx;
    dx = XW'(d);
    if (dx == '0) begin
      return XW'(1);
    end else if (dx > MAX_X) begin
      return MAX_X;
    end
    return dx;
  endfunction

  assign accept       = texel_i.valid && push_ready_i;
  assign texel_i.ready = push_ready_i;
  assign push_valid_o = texel_i.valid;

  // position of this texel, a first pixel restarts at the origin
  always_comb begin
    col_cur = texel_i.first_pixel ? '0 : col_q;
    row_cur = texel_i.first_pixel ? '0 : row_q;
    tw_x    = eff_dim(cfg_i.texture_width);
    th_x    = eff_dim(cfg_i.texture_height);
    col_inc = XW'(col_cur) + XW'(1);
    row_inc = XW'(row_cur) + XW'(1);
    end_col = col_inc >= tw_x;
    end_row = row_inc >= th_x;
  end

  // classification
  always_comb begin
    push_item_o.key     = {texel_i.red, texel_i.green, texel_i.blue};
    push_item_o.visible = (XW'(col_cur) < XW'(cfg_i.image_width)) &&
                          (XW'(row_cur) < XW'(cfg_i.image_height)) &&
                          (texel_i.alpha > cfg_i.alpha_threshold);
    push_item_o.first   = texel_i.first_pixel;
    push_item_o.last    = end_col && end_row;
  end

  // raster step
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (end_col) begin
        col_d = '0;
        row_d = end_row ? '0 : CW'(row_inc);
      end else begin
        col_d = CW'(col_inc);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### src/rgbpal_queue.sv
// ---------------------------------------------------------------------------
// rgbpal_queue
// Small first-in first-out queue of classified texels between front and back.
// ---------------------------------------------------------------------------
module rgbpal_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  rgbpal_pkg::item_t push_item_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output rgbpal_pkg::item_t pop_item_o
);

  localparam int unsigned DEPTH = rgbpal_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  rgbpal_pkg::item_t slots_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] fill_q, fill_d;
  logic          do_push, do_pop;

  assign push_ready_o = fill_q != NW'(DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_item_o   = slots_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + NW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_item_i;
    end
  end

endmodule

### src/rgbpal_back.sv
// ---------------------------------------------------------------------------
// rgbpal_back
// Looks up each opaque texel in the color tag memory, one entry a cycle,
// appends new colors and drives the result register.
// ---------------------------------------------------------------------------
module rgbpal_back #(
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  rgbpal_pkg::item_t    pop_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rgbpal_pkg::result_t  out_o
);

  localparam int unsigned SLOT_W = $clog2(PALETTE_SIZE);
  localparam int unsigned CNT_W  = $clog2(PALETTE_SIZE + 1);
  localparam int unsigned DEPTH  = PALETTE_SIZE - 1;
  localparam int unsigned KEY_W  = rgbpal_pkg::KEY_W;

  rgbpal_pkg::back_state_e state_q, state_d;
  rgbpal_pkg::item_t       item_q, item_d;
  rgbpal_pkg::result_t     res_q, res_d, out_q, out_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, ptr_q, ptr_d;
  logic [SLOT_W-1:0]       rd_slot_q, rd_slot_d;
  logic                    rdv_q, rdv_d, out_valid_q, out_valid_d;

  // tag memory, slot s lives at address s-1
  logic [KEY_W-1:0]  tag_mem [DEPTH];
  logic [KEY_W-1:0]  rdata_q;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rd_slot_d   = rd_slot_q;
    rdv_d       = 1'b0;
    out_valid_d = out_valid_q;
    pop_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = SLOT_W'(cnt_q - CNT_W'(1));
    mem_raddr   = SLOT_W'(ptr_q - CNT_W'(1));

    // result word taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rgbpal_pkg::BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          item_d            = pop_item_i;
          res_d             = '0;
          res_d.entry_color = rgbpal_pkg::NO_COLOR;
          ptr_d             = CNT_W'(1);
          if (pop_item_i.first) begin
            cnt_d = CNT_W'(1);
          end
          state_d = pop_item_i.visible ? rgbpal_pkg::BK_SEARCH : rgbpal_pkg::BK_EMIT;
        end
      end

      rgbpal_pkg::BK_SEARCH: begin
        if (rdv_q && (rdata_q == item_q.key)) begin
          // hit on a stored color
          res_d.pixel_index = rgbpal_pkg::INDEX_W'(rd_slot_q);
          state_d           = rgbpal_pkg::BK_EMIT;
        end else if (ptr_q < cnt_q) begin
          // issue the next tag read
          mem_re    = 1'b1;
          rd_slot_d = SLOT_W'(ptr_q);
          rdv_d     = 1'b1;
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          // miss: append if there is room
          if (cnt_q < CNT_W'(PALETTE_SIZE)) begin
            mem_we            = 1'b1;
            res_d.pixel_index = rgbpal_pkg::INDEX_W'(cnt_q);
            res_d.new_entry   = 1'b1;
            res_d.entry_slot  = rgbpal_pkg::INDEX_W'(cnt_q);
            res_d.entry_color = rgbpal_pkg::rgb555(item_q.key);
            cnt_d             = cnt_q + CNT_W'(1);
          end else begin
            res_d.pixel_index = rgbpal_pkg::FULL_INDEX;
          end
          state_d = rgbpal_pkg::BK_EMIT;
        end
      end

      rgbpal_pkg::BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d               = res_q;
          out_d.palette_count = rgbpal_pkg::COUNT_W'(cnt_q);
          out_d.last_pixel    = item_q.last;
          out_valid_d         = 1'b1;
          state_d             = rgbpal_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = rgbpal_pkg::BK_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgbpal_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_W'(1);
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    res_q     <= res_d;
    out_q     <= out_d;
    ptr_q     <= ptr_d;
    rd_slot_q <= rd_slot_d;
  end

  // tag memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= item_q.key;
    end
    if (mem_re) begin
      rdata_q <= tag_mem[mem_raddr];
    end
  end

endmodule
